// ===== src/mfe_pkg.sv =====
// Shared constants and types for the multichannel frame energy block.
`default_nettype none

package mfe_pkg;

	localparam int CHANNELS      = 128;
	localparam int CH_BITS       = $clog2(CHANNELS);
	localparam int MAX_HOPS      = 8;
	localparam int POS_BITS      = $clog2(MAX_HOPS);
	localparam int WIN_BITS      = 4;
	localparam int SAMPLE_BITS   = 16;
	localparam int SQ_BITS       = 2 * SAMPLE_BITS;
	localparam int ACC_BITS      = 42;
	localparam int SUM_BITS      = 46;
	localparam int ENERGY_BITS   = 45;
	localparam int FRAME_BITS    = 16;
	localparam int HOP_BITS      = 12;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 12;

	localparam int RES_DEPTH     = 3;
	localparam int RES_PTR_BITS  = 2;
	localparam int RES_CNT_BITS  = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_HOP_LENGTH  = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_HOPS = 1'd1;

	localparam logic [HOP_BITS-1:0] HOP_LENGTH_RST  = 12'd160;
	localparam logic [WIN_BITS-1:0] WINDOW_HOPS_RST = 4'd2;

	typedef struct packed {
		logic [ACC_BITS-1:0]   acc;
		logic [HOP_BITS-1:0]   cnt;
		logic [POS_BITS-1:0]   pos;
		logic [WIN_BITS-1:0]   seen;
		logic [SUM_BITS-1:0]   wsum;
		logic [FRAME_BITS-1:0] frame;
	} chan_state_t;

	typedef logic [MAX_HOPS-1:0][ACC_BITS-1:0] ring_row_t;

	typedef struct packed {
		logic [CH_BITS-1:0]     out_channel;
		logic [FRAME_BITS-1:0]  frame_index;
		logic [ENERGY_BITS-1:0] window_energy;
	} result_t;

endpackage

`default_nettype wire

// ===== src/mfe_cfg_if.sv =====
// Configuration write channel.
`default_nettype none

interface mfe_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [mfe_pkg::CFG_IDX_BITS-1:0]   index;
	logic [mfe_pkg::CFG_DATA_BITS-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/mfe_in_if.sv =====
// Sample input channel.
`default_nettype none

interface mfe_in_if;
	logic                                   valid;
	logic                                   ready;
	logic [mfe_pkg::CH_BITS-1:0]            channel;
	logic signed [mfe_pkg::SAMPLE_BITS-1:0] sample;
	logic                                   restart;

	modport source (output valid, channel, sample, restart, input ready);
	modport sink   (input valid, channel, sample, restart, output ready);
endinterface

`default_nettype wire

// ===== src/mfe_out_if.sv =====
// Frame energy result channel.
`default_nettype none

interface mfe_out_if;
	logic                              valid;
	logic                              ready;
	logic [mfe_pkg::CH_BITS-1:0]       out_channel;
	logic [mfe_pkg::FRAME_BITS-1:0]    frame_index;
	logic [mfe_pkg::ENERGY_BITS-1:0]   window_energy;

	modport source (output valid, out_channel, frame_index, window_energy, input ready);
	modport sink   (input valid, out_channel, frame_index, window_energy, output ready);
endinterface

`default_nettype wire

// ===== src/multichannel_frame_energy.sv =====
// Path: a sample is registered in stage 1; one that closes a hop then enters the result queue.
// Throughput: one sample word per cycle while input is ready; per-channel state memory is read at
//   acceptance and written back in the following cycle, with a bypass for back-to-back channels.
// Output: a three-entry result queue keeps input acceptance off the output ready.
// Reset: hop_length 160, window_hops 2, every channel starts from zero state;
//   the hop sum ring holds no value until written, no clearing pass.
`default_nettype none

module multichannel_frame_energy (
	input wire logic   clk,
	input wire logic   arst_n,
	mfe_cfg_if.sink    cfg,
	mfe_in_if.sink     samples,
	mfe_out_if.source  results
);

	// configuration registers
	logic [mfe_pkg::HOP_BITS-1:0] hop_length_q;
	logic [mfe_pkg::WIN_BITS-1:0] window_hops_q;
	logic [mfe_pkg::HOP_BITS-1:0] len_eff;
	logic [mfe_pkg::WIN_BITS-1:0] wh_eff;

	// stage 1
	logic                             in_acc;
	logic signed [mfe_pkg::SQ_BITS-1:0] prod;
	logic                             s1_valid;
	logic [mfe_pkg::CH_BITS-1:0]      ch_s1;
	logic                             restart_s1;
	logic [mfe_pkg::SQ_BITS-1:0]      sq_s1;
	mfe_pkg::chan_state_t             state_rd_s1;
	mfe_pkg::ring_row_t               ring_rd_s1;

	// per-channel storage
	mfe_pkg::chan_state_t             state_mem [mfe_pkg::CHANNELS];
	mfe_pkg::ring_row_t               ring_mem  [mfe_pkg::CHANNELS];
	logic [mfe_pkg::CHANNELS-1:0]     vld_q;

	// write-back bypass
	mfe_pkg::chan_state_t             wb_state_q;
	logic [mfe_pkg::CH_BITS-1:0]      wb_ch_q;
	logic                             wb_vld_q;
	mfe_pkg::ring_row_t               wbr_row_q;
	logic [mfe_pkg::CH_BITS-1:0]      wbr_ch_q;
	logic                             wbr_vld_q;

	// update logic
	mfe_pkg::chan_state_t             cur;
	mfe_pkg::chan_state_t             state_new;
	mfe_pkg::ring_row_t               row;
	mfe_pkg::ring_row_t               ring_new;
	logic [mfe_pkg::ACC_BITS-1:0]     acc_sum;
	logic [mfe_pkg::HOP_BITS-1:0]     cnt_inc;
	logic [mfe_pkg::WIN_BITS-1:0]     seen_c;
	logic                             full;
	logic [mfe_pkg::POS_BITS-1:0]     old_idx;
	logic [mfe_pkg::SUM_BITS-1:0]     wsum_add;
	logic [mfe_pkg::SUM_BITS-1:0]     wsum_new;
	logic                             emit;
	mfe_pkg::result_t                 res_new;

	// result queue
	mfe_pkg::result_t                 res_q [mfe_pkg::RES_DEPTH];
	logic [mfe_pkg::RES_PTR_BITS-1:0] wr_ptr_q;
	logic [mfe_pkg::RES_PTR_BITS-1:0] rd_ptr_q;
	logic [mfe_pkg::RES_CNT_BITS-1:0] res_cnt_q;
	logic                             push;
	logic                             pop;
	mfe_pkg::result_t                 res_head;

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_length_q  <= mfe_pkg::HOP_LENGTH_RST;
			window_hops_q <= mfe_pkg::WINDOW_HOPS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				mfe_pkg::REG_HOP_LENGTH: begin
					hop_length_q <= cfg.data[mfe_pkg::HOP_BITS-1:0];
				end
				mfe_pkg::REG_WINDOW_HOPS: begin
					window_hops_q <= cfg.data[mfe_pkg::WIN_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		len_eff = (hop_length_q == '0) ? mfe_pkg::HOP_BITS'(1) : hop_length_q;
		if (window_hops_q == '0)
			wh_eff = mfe_pkg::WIN_BITS'(1);
		else if (window_hops_q > mfe_pkg::WIN_BITS'(mfe_pkg::MAX_HOPS))
			wh_eff = mfe_pkg::WIN_BITS'(mfe_pkg::MAX_HOPS);
		else
			wh_eff = window_hops_q;
	end

	// ---------------- acceptance and stage 1 ----------------
	assign in_acc = samples.valid && samples.ready;
	assign prod   = samples.sample * samples.sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else
			s1_valid <= in_acc;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ch_s1      <= samples.channel;
			restart_s1 <= samples.restart;
			sq_s1      <= unsigned'(prod);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			state_rd_s1 <= state_mem[samples.channel];
		if (s1_valid)
			state_mem[ch_s1] <= state_new;
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			ring_rd_s1 <= ring_mem[samples.channel];
		if (s1_valid && emit)
			ring_mem[ch_s1] <= ring_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			wb_vld_q  <= 1'b0;
			wbr_vld_q <= 1'b0;
		end else begin
			if (s1_valid) begin
				vld_q[ch_s1] <= 1'b1;
				wb_vld_q     <= 1'b1;
			end
			if (s1_valid && emit)
				wbr_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid) begin
			wb_state_q <= state_new;
			wb_ch_q    <= ch_s1;
		end
		if (s1_valid && emit) begin
			wbr_row_q <= ring_new;
			wbr_ch_q  <= ch_s1;
		end
	end

	always_comb begin
		// take the newest copy of the channel state
		cur = state_rd_s1;
		if (wb_vld_q && wb_ch_q == ch_s1)
			cur = wb_state_q;
		else if (!vld_q[ch_s1])
			cur = '0;
		if (restart_s1)
			cur = '0;

		row = (wbr_vld_q && wbr_ch_q == ch_s1) ? wbr_row_q : ring_rd_s1;

		acc_sum  = cur.acc + mfe_pkg::ACC_BITS'(sq_s1);
		cnt_inc  = cur.cnt + 1'b1;
		emit     = (cnt_inc >= len_eff) || (cnt_inc == '0);
		seen_c   = (cur.seen > wh_eff) ? wh_eff : cur.seen;
		full     = (seen_c >= wh_eff);
		// ring wraps at MAX_HOPS, so a full-depth window points back at pos
		old_idx  = cur.pos - wh_eff[mfe_pkg::POS_BITS-1:0];
		wsum_add = cur.wsum + mfe_pkg::SUM_BITS'(acc_sum);
		wsum_new = full ? (wsum_add - mfe_pkg::SUM_BITS'(row[old_idx])) : wsum_add;

		state_new     = cur;
		state_new.acc = acc_sum;
		state_new.cnt = cnt_inc;
		ring_new      = row;
		if (emit) begin
			state_new.acc   = '0;
			state_new.cnt   = '0;
			state_new.pos   = cur.pos + 1'b1;
			state_new.seen  = full ? seen_c : (seen_c + 1'b1);
			state_new.wsum  = wsum_new;
			state_new.frame = cur.frame + 1'b1;
			ring_new[cur.pos] = acc_sum;
		end

		res_new.out_channel   = ch_s1;
		res_new.frame_index   = cur.frame;
		res_new.window_energy = wsum_new[mfe_pkg::ENERGY_BITS-1:0];
	end

	// ---------------- result queue ----------------
	assign push = s1_valid && emit;
	assign pop  = results.valid && results.ready;

	// admit a word only while the queue can absorb it and the one in flight
	assign samples.ready = ((3'(res_cnt_q) + 3'(s1_valid)) < 3'(mfe_pkg::RES_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == mfe_pkg::RES_PTR_BITS'(mfe_pkg::RES_DEPTH - 1)) ?
					'0 : (wr_ptr_q + 1'b1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == mfe_pkg::RES_PTR_BITS'(mfe_pkg::RES_DEPTH - 1)) ?
					'0 : (rd_ptr_q + 1'b1);
			if (push && !pop)
				res_cnt_q <= res_cnt_q + 1'b1;
			else if (pop && !push)
				res_cnt_q <= res_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			res_q[wr_ptr_q] <= res_new;
	end

	assign res_head              = res_q[rd_ptr_q];
	assign results.valid         = (res_cnt_q != '0);
	assign results.out_channel   = res_head.out_channel;
	assign results.frame_index   = res_head.frame_index;
	assign results.window_energy = res_head.window_energy;

	// ---------------- assertions ----------------
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (res_cnt_q != mfe_pkg::RES_CNT_BITS'(mfe_pkg::RES_DEPTH) || pop))
		else $error("result queue overflow");

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (state_new.seen != '0 && state_new.seen <= wh_eff))
		else $error("hop count outside window");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_cnt_q != '0 && !pop) |=> (res_cnt_q != '0))
		else $error("pending result lost");

endmodule

`default_nettype wire
